### rtl/core/grid_dda_column_raycaster_core_assert.svh
// ----------------------------------------------------------------------------
// Raycaster assertion macros
// Shared property wrappers for the raycaster checkers.
// ----------------------------------------------------------------------------
`ifndef GRID_DDA_COLUMN_RAYCASTER_CORE_ASSERT_SVH
`define GRID_DDA_COLUMN_RAYCASTER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GDR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GDR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/gdr_pkg.sv
// ----------------------------------------------------------------------------
// Raycaster package
// Shared constants and divider interface types.
// ----------------------------------------------------------------------------
package gdr_pkg;

	localparam int MAP_SIZE_DEF = 32;
	localparam int SCREEN_COLUMNS_DEF = 640;
	localparam int SCREEN_ROWS_DEF = 480;

	localparam int DIV_W = 40;
	localparam int DIV_CNT_W = 6;

	localparam logic OP_CAST  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	localparam logic [2:0] REG_POS_X   = 3'd0;
	localparam logic [2:0] REG_POS_Y   = 3'd1;
	localparam logic [2:0] REG_DIR_X   = 3'd2;
	localparam logic [2:0] REG_DIR_Y   = 3'd3;
	localparam logic [2:0] REG_PLANE_X = 3'd4;
	localparam logic [2:0] REG_PLANE_Y = 3'd5;

	typedef struct packed {
		logic                 start;
		logic [DIV_W-1:0]     num;
		logic [DIV_W-1:0]     den;
		logic [DIV_CNT_W-1:0] bits;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quo;
	} div_rsp_t;

endpackage

### rtl/core/gdr_div.sv
// ----------------------------------------------------------------------------
// Raycaster divider
// Restoring divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gdr_div (
	input  logic                clk,
	input  logic                arst_n,
	input  gdr_pkg::div_req_t   req,
	output gdr_pkg::div_rsp_t   rsp
);

	localparam int W = gdr_pkg::DIV_W;

	logic [W-1:0] num_q, den_q, rem_q, quo_q;
	logic [gdr_pkg::DIV_CNT_W-1:0] cnt_q;
	logic busy_q, done_q;
	logic [W:0] trial, diff;
	logic ge;

	assign trial = {rem_q, num_q[W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.bits;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == gdr_pkg::DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[W-1:0] : trial[W-1:0];
			quo_q <= {quo_q[W-2:0], ge};
			num_q <= {num_q[W-2:0], 1'b0};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

endmodule

### rtl/core/grid_dda_column_raycaster_core.sv
// ----------------------------------------------------------------------------
// Grid DDA column raycaster core
// Casts one ray per screen column through a wall-code grid map.
// ----------------------------------------------------------------------------
// A map write completes in the cycle it is accepted. A cast is handled one at a
// time. A cast walks at most 2*MAP_SIZE grid steps; a cast that escapes skips the
// line height division. The next transaction is taken in the cycle after the
// result is loaded, which waits while a previous result is still stalled. Cast
// time is set by one shared bit-serial divider that runs twice per cast (two
// reciprocals, 33 bits each) and once more on a hit (line height, 29 bits), and
// by the map memory, whose registered read adds the S_CHECK state to every grid
// step. The camera offset uses a constant reciprocal on the shared multiplier.
// No clearing pass is run; every cell must be written before it is cast against.
module grid_dda_column_raycaster_core #(
	parameter int MAP_SIZE       = gdr_pkg::MAP_SIZE_DEF,
	parameter int SCREEN_COLUMNS = gdr_pkg::SCREEN_COLUMNS_DEF,
	parameter int SCREEN_ROWS    = gdr_pkg::SCREEN_ROWS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        operation,
	input  logic [9:0]  column,
	input  logic [9:0]  cell_index,
	input  logic [2:0]  cell_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [9:0]  column_out,
	output logic [8:0]  draw_start,
	output logic [8:0]  draw_end,
	output logic [2:0]  wall_code,
	output logic        hit_side,
	output logic        escaped
);

	localparam int CELLS  = MAP_SIZE * MAP_SIZE;
	localparam int AW     = $clog2(CELLS);
	localparam int STEP_W = $clog2(2 * MAP_SIZE + 1);
	localparam int HALF_ROWS = SCREEN_ROWS / 2;
	localparam int W = gdr_pkg::DIV_W;
	localparam logic [W-1:0] LINE_NUM  = W'(SCREEN_ROWS) << 27;
	localparam logic [W-1:0] RECIP_NUM = W'(1) << (W - 1);
	localparam int CAM_S  = 27 + $clog2(SCREEN_COLUMNS);
	localparam int CAM_SH = CAM_S - 17;
	localparam longint CAM_M = ((longint'(1) << CAM_S) + longint'(SCREEN_COLUMNS) - 1)
		/ longint'(SCREEN_COLUMNS);

	typedef enum logic [13:0] {
		S_IDLE  = 14'b00000000000001,
		S_CAM   = 14'b00000000000010,
		S_RMX   = 14'b00000000000100,
		S_RMY   = 14'b00000000001000,
		S_DX0   = 14'b00000000010000,
		S_DX    = 14'b00000000100000,
		S_DY    = 14'b00000001000000,
		S_SX    = 14'b00000010000000,
		S_SY    = 14'b00000100000000,
		S_SY2   = 14'b00001000000000,
		S_STEP  = 14'b00010000000000,
		S_CHECK = 14'b00100000000000,
		S_LINE  = 14'b01000000000000,
		S_DONE  = 14'b10000000000000
	} state_t;

	state_t state_q, state_d;

	logic [20:0] pos_x_q, pos_y_q;
	logic [17:0] dir_x_q, dir_y_q, plane_x_q, plane_y_q;

	logic cfg_wr;
	assign cfg_wr = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q   <= 21'd1441792;
			pos_y_q   <= 21'd786432;
			dir_x_q   <= 18'h30000;
			dir_y_q   <= 18'd0;
			plane_x_q <= 18'd0;
			plane_y_q <= 18'd43254;
		end else if (cfg_wr) begin
			unique case (paddr[4:2])
				gdr_pkg::REG_POS_X:   pos_x_q   <= pwdata[20:0];
				gdr_pkg::REG_POS_Y:   pos_y_q   <= pwdata[20:0];
				gdr_pkg::REG_DIR_X:   dir_x_q   <= pwdata[17:0];
				gdr_pkg::REG_DIR_Y:   dir_y_q   <= pwdata[17:0];
				gdr_pkg::REG_PLANE_X: plane_x_q <= pwdata[17:0];
				gdr_pkg::REG_PLANE_Y: plane_y_q <= pwdata[17:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			gdr_pkg::REG_POS_X:   prdata = {11'd0, pos_x_q};
			gdr_pkg::REG_POS_Y:   prdata = {11'd0, pos_y_q};
			gdr_pkg::REG_DIR_X:   prdata = {14'd0, dir_x_q};
			gdr_pkg::REG_DIR_Y:   prdata = {14'd0, dir_y_q};
			gdr_pkg::REG_PLANE_X: prdata = {14'd0, plane_x_q};
			gdr_pkg::REG_PLANE_Y: prdata = {14'd0, plane_y_q};
			default:              prdata = 32'd0;
		endcase
	end

	logic [9:0] col_q;
	logic signed [27:0] cam_q;
	logic signed [30:0] rx_q, ry_q;
	logic [31:0] dx_q, dy_q;
	logic [W-1:0] sx_q, sy_q;
	logic signed [7:0] mx_q, my_q;
	logic side_q, perp_zero_q, esc_q;
	logic [STEP_W-1:0] steps_q;
	logic signed [50:0] mul_q;
	logic [2:0] rd_q, code_q;
	logic [8:0] ds_q, de_q;

	logic out_valid_q;
	logic [9:0] column_out_q;
	logic [8:0] draw_start_q, draw_end_q;
	logic [2:0] wall_code_q;
	logic hit_side_q, escaped_q;

	gdr_pkg::div_req_t div_req;
	gdr_pkg::div_rsp_t div_rsp;

	gdr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	logic accept, cast_go, write_go, out_load;
	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign cast_go  = accept && (operation == gdr_pkg::OP_CAST);
	assign write_go = accept && (operation == gdr_pkg::OP_WRITE);
	assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	logic signed [17:0] mul_a;
	logic signed [32:0] mul_b;
	logic signed [50:0] mul_p;
	logic [16:0] fx_sel, fy_sel;
	logic [26:0] cam_quo;

	assign fx_sel = rx_q[30] ? {1'b0, pos_x_q[15:0]} : 17'd65536 - {1'b0, pos_x_q[15:0]};
	assign fy_sel = ry_q[30] ? {1'b0, pos_y_q[15:0]} : 17'd65536 - {1'b0, pos_y_q[15:0]};

	always_comb begin
		unique case (state_q)
			S_CAM: begin
				mul_a = $signed({8'd0, col_q});
				mul_b = $signed(33'(CAM_M));
			end
			S_RMX: begin
				mul_a = $signed(plane_x_q);
				mul_b = $signed({{5{cam_q[27]}}, cam_q});
			end
			S_RMY: begin
				mul_a = $signed(plane_y_q);
				mul_b = $signed({{5{cam_q[27]}}, cam_q});
			end
			S_SX: begin
				mul_a = $signed({1'b0, fx_sel});
				mul_b = $signed({1'b0, dx_q});
			end
			default: begin
				mul_a = $signed({1'b0, fy_sel});
				mul_b = $signed({1'b0, dy_q});
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;
	assign cam_quo = 27'(mul_p >> CAM_SH);

	logic [30:0] abs_rx, abs_ry;
	assign abs_rx = rx_q[30] ? 31'(-rx_q) : 31'(rx_q);
	assign abs_ry = ry_q[30] ? 31'(-ry_q) : 31'(ry_q);

	logic x_first;
	logic signed [7:0] nmx, nmy;
	logic in_map;
	logic [AW-1:0] rd_addr;
	logic [W-1:0] perp;

	assign x_first = sx_q < sy_q;
	assign nmx = x_first ? (rx_q[30] ? mx_q - 8'sd1 : mx_q + 8'sd1) : mx_q;
	assign nmy = x_first ? my_q : (ry_q[30] ? my_q - 8'sd1 : my_q + 8'sd1);
	assign in_map = !nmx[7] && !nmy[7] && (int'(nmx) < MAP_SIZE) && (int'(nmy) < MAP_SIZE);
	assign rd_addr = AW'(int'(nmy) * MAP_SIZE + int'(nmx));
	assign perp = side_q ? (sy_q - W'(dy_q)) : (sx_q - W'(dx_q));

	logic [28:0] line_h, half_h;
	logic signed [30:0] ds_w;
	logic [30:0] de_w;
	assign line_h = perp_zero_q ? 29'(2 * SCREEN_ROWS + 2) : div_rsp.quo[28:0];
	assign half_h = line_h >> 1;
	assign ds_w = 31'(HALF_ROWS) - $signed({2'b00, half_h});
	assign de_w = 31'(HALF_ROWS) + {2'b00, half_h};

	logic hit;
	assign hit = (rd_q != 3'd0);

	always_comb begin
		div_req.start = 1'b0;
		div_req.num   = RECIP_NUM;
		div_req.den   = W'(abs_rx);
		div_req.bits  = gdr_pkg::DIV_CNT_W'(33);
		state_d       = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cast_go) begin
					state_d = S_CAM;
				end
			end
			S_CAM:  state_d = S_RMX;
			S_RMX:  state_d = S_RMY;
			S_RMY:  state_d = S_DX0;
			S_DX0: begin
				div_req.start = 1'b1;
				state_d       = S_DX;
			end
			S_DX: begin
				if (div_rsp.done) begin
					div_req.start = 1'b1;
					div_req.den   = W'(abs_ry);
					state_d       = S_DY;
				end
			end
			S_DY:   if (div_rsp.done) state_d = S_SX;
			S_SX:   state_d = S_SY;
			S_SY:   state_d = S_SY2;
			S_SY2:  state_d = S_STEP;
			S_STEP: state_d = in_map ? S_CHECK : S_DONE;
			S_CHECK: begin
				if (hit) begin
					div_req.start = 1'b1;
					div_req.num   = LINE_NUM;
					div_req.den   = perp;
					div_req.bits  = gdr_pkg::DIV_CNT_W'(29);
					state_d       = S_LINE;
				end else if (steps_q == STEP_W'(2 * MAP_SIZE)) begin
					state_d = S_DONE;
				end else begin
					state_d = S_STEP;
				end
			end
			S_LINE: if (div_rsp.done) state_d = S_DONE;
			S_DONE: if (out_load) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	logic [2:0] map_q [CELLS];

	always_ff @(posedge clk) begin
		if (write_go && (32'(cell_index) < CELLS)) begin
			map_q[AW'(cell_index)] <= cell_value;
		end
		if ((state_q == S_STEP) && in_map) begin
			rd_q <= map_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		mul_q <= mul_p;
		if (cast_go) begin
			col_q <= column;
		end
		unique case (state_q)
			S_CAM: begin
				cam_q <= $signed({1'b0, cam_quo}) - 28'sd65536;
			end
			S_RMY: begin
				rx_q <= $signed({mul_q[45], mul_q[45:16]})
					+ $signed({{13{dir_x_q[17]}}, dir_x_q});
			end
			S_DX0: begin
				ry_q <= $signed({mul_q[45], mul_q[45:16]})
					+ $signed({{13{dir_y_q[17]}}, dir_y_q});
			end
			S_DX: begin
				if (div_rsp.done) begin
					dx_q <= (rx_q == 31'sd0 || div_rsp.quo[32]) ? '1 : div_rsp.quo[31:0];
				end
			end
			S_DY: begin
				if (div_rsp.done) begin
					dy_q <= (ry_q == 31'sd0 || div_rsp.quo[32]) ? '1 : div_rsp.quo[31:0];
				end
			end
			S_SY: begin
				sx_q <= W'(mul_q[48:16]);
			end
			S_SY2: begin
				sy_q    <= W'(mul_q[48:16]);
				mx_q    <= $signed({3'b000, pos_x_q[20:16]});
				my_q    <= $signed({3'b000, pos_y_q[20:16]});
				steps_q <= '0;
				esc_q   <= 1'b0;
			end
			S_STEP: begin
				if (x_first) begin
					sx_q   <= sx_q + W'(dx_q);
					side_q <= 1'b0;
				end else begin
					sy_q   <= sy_q + W'(dy_q);
					side_q <= 1'b1;
				end
				mx_q    <= nmx;
				my_q    <= nmy;
				steps_q <= steps_q + 1'b1;
				if (!in_map) begin
					esc_q <= 1'b1;
				end
			end
			S_CHECK: begin
				code_q      <= rd_q;
				perp_zero_q <= (perp == '0);
				if (!hit && (steps_q == STEP_W'(2 * MAP_SIZE))) begin
					esc_q <= 1'b1;
				end
			end
			S_LINE: begin
				if (div_rsp.done) begin
					ds_q <= ds_w[30] ? 9'd0 : ds_w[8:0];
					de_q <= (de_w >= 31'(SCREEN_ROWS)) ? 9'(SCREEN_ROWS - 1) : de_w[8:0];
				end
			end
			default: ;
		endcase
		if (out_load) begin
			column_out_q <= col_q;
			escaped_q    <= esc_q;
			draw_start_q <= esc_q ? 9'd0 : ds_q;
			draw_end_q   <= esc_q ? 9'd0 : de_q;
			wall_code_q  <= esc_q ? 3'd0 : code_q;
			hit_side_q   <= esc_q ? 1'b0 : side_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign column_out = column_out_q;
	assign draw_start = draw_start_q;
	assign draw_end   = draw_end_q;
	assign wall_code  = wall_code_q;
	assign hit_side   = hit_side_q;
	assign escaped    = escaped_q;

endmodule

### rtl/core/gdr_checker.sv
// ----------------------------------------------------------------------------
// Raycaster port checker
// Port-level properties of the raycaster core, bound to the top level.
// ----------------------------------------------------------------------------
`include "grid_dda_column_raycaster_core_assert.svh"

module gdr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        operation,
	input logic        out_valid,
	input logic        out_stall,
	input logic [9:0]  column_out,
	input logic [8:0]  draw_start,
	input logic [8:0]  draw_end,
	input logic [2:0]  wall_code,
	input logic        hit_side,
	input logic        escaped
);

	`GDR_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(column_out), "stalled result transaction dropped or changed")
	`GDR_ASSERT_NOW(a_escape_zero, clk, arst_n, out_valid && escaped, draw_start == 9'd0 && draw_end == 9'd0 && wall_code == 3'd0 && !hit_side, "escaped result carries nonzero fields")
	`GDR_ASSERT_NOW(a_hit_sane, clk, arst_n, out_valid && !escaped, wall_code != 3'd0 && draw_start <= draw_end, "hit result has empty wall code or inverted slice")
	`GDR_ASSERT_NEXT(a_write_idle, clk, arst_n, in_valid && !in_stall && operation, !in_stall, "map write transaction left the core busy")

endmodule

bind grid_dda_column_raycaster_core gdr_checker u_gdr_checker (.*);
